/* rtl/wenc_pkg.sv */
`default_nettype none
package wenc_pkg;

  localparam int unsigned WHEEL_COUNT = 2;
  localparam int unsigned WHEEL_W     = 1;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned REV_W       = 8;
  localparam int unsigned COUNT_W     = REV_W + 1;
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned SPEED_W     = 32;
  localparam int unsigned DIST_W      = 48;
  localparam int unsigned CM_W        = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  // shared multiplier operand widths
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 20;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // count * distance per notch, then * 1e6
  localparam int unsigned CNT_CM_W = COUNT_W + CM_W;
  localparam int unsigned NUM_W    = CNT_CM_W + MUL_B_W;
  localparam int unsigned STEP_W   = $clog2(NUM_W);

  localparam logic [MUL_B_W-1:0] US_PER_SECOND = MUL_B_W'(1000000);
  localparam logic [CM_W-1:0]    CM_RESET      = CM_W'(4096);
  localparam logic [REV_W-1:0]   NPR_RESET     = REV_W'(20);
  localparam logic [COUNT_W-1:0] FULL_REV      = COUNT_W'(256);

  localparam int unsigned OUT_DATA_W = TOTAL_W + DIST_W + SPEED_W;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOTCH_PITCH     = 1'b0,
    CFG_NOTCHES_PER_REV = 1'b1
  } cfg_idx_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIST  = 7'b0000010,
    S_SPD1  = 7'b0000100,
    S_SPD2  = 7'b0001000,
    S_DIVST = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } seq_state_e;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage : wenc_pkg
`default_nettype wire

/* rtl/wenc_mul.sv */
`default_nettype none
module wenc_mul (
  input  wire                              clk_i,
  input  wire  [wenc_pkg::MUL_A_W-1:0]     a_i,
  input  wire  [wenc_pkg::MUL_B_W-1:0]     b_i,
  output logic [wenc_pkg::MUL_P_W-1:0]     p_o
);
  import wenc_pkg::*;

  logic [MUL_P_W-1:0] p_q;
  logic [MUL_P_W-1:0] p_d;

  assign p_d = MUL_P_W'(a_i) * MUL_P_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule : wenc_mul
`default_nettype wire

/* rtl/wenc_div.sv */
`default_nettype none
module wenc_div (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start_i,
  input  wire  [wenc_pkg::NUM_W-1:0]      dividend_i,
  input  wire  [wenc_pkg::TIME_W-1:0]     divisor_i,
  output logic                            done_o,
  output logic [wenc_pkg::NUM_W-1:0]      quotient_o
);
  import wenc_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [TIME_W-1:0] rem_q, rem_d;
  logic [TIME_W-1:0] dsr_q, dsr_d;

  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              fits;

  // restoring division, one quotient bit per cycle, dividend MSB first
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[NUM_W-2:0], fits};
      rem_d = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      cnt_d = cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule : wenc_div
`default_nettype wire

/* rtl/wheel_encoder_odometry_unit.sv */
`default_nettype none
// Wheel encoder odometry. Each s_axis transaction is one notch edge: tuser selects the wheel,
// tdata carries its microsecond timestamp. Every edge yields one m_axis transaction with the
// wheel's wrapping notch total, its distance (total times the distance-per-notch register,
// Q.12 cm) and its latest speed (Q.12 cm/s). When the notches counted in the current
// revolution reach notches_per_rev (0 means 256) the speed is recomputed as
// count * distance per notch * 1e6 / elapsed_us, truncated and saturated to 32 bits; a zero
// interval keeps the old speed and leaves speed_new low. Each wheel's first interval starts
// at time zero. s_axis_tready is low while an edge is in work. An edge that does not refresh
// the speed goes through accept, distance product, count product and output load before the
// next one can be accepted; one that refreshes the speed also goes through the second product,
// the divider start and the bit-serial divider, which produces one of 45 quotient bits per cycle.
// One shared 32x20 multiplier computes distance and the speed dividend in turn. A finished
// result waits in the output register, so the next edge can be taken and worked on while
// m_axis is stalled; that edge then holds in its last step until the register frees up.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write it only
// while idle, as the block itself does not enforce this.
module wheel_encoder_odometry_unit (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // configuration write port
  input  wire                                  cfg_we_i,
  input  wire  [wenc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire  [wenc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // edge events
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [wenc_pkg::TIME_W-1:0]          s_axis_tdata,   // [63:0] now_us
  input  wire  [wenc_pkg::WHEEL_W-1:0]         s_axis_tuser,   // [0] wheel
  // results
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [wenc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // [31:0] total_notches,
                                                               // [79:32] distance_q12,
                                                               // [111:80] speed_q12
  output logic [wenc_pkg::OUT_USER_W-1:0]      m_axis_tuser    // [0] which_wheel,
                                                               // [1] speed_new
);
  import wenc_pkg::*;

  // config registers
  logic [CM_W-1:0]  cm_q;
  logic [REV_W-1:0] npr_q;

  // per-wheel state
  logic [TOTAL_W-1:0] notch_total_q   [WHEEL_COUNT];
  logic [REV_W-1:0]   rev_notches_q   [WHEEL_COUNT];
  logic [TIME_W-1:0]  last_rev_time_q [WHEEL_COUNT];
  logic [SPEED_W-1:0] wheel_speed_q   [WHEEL_COUNT];

  // sequencer
  seq_state_e state_q, state_d;

  // per-transaction working registers
  logic [WHEEL_W-1:0] wheel_q;
  logic [TOTAL_W-1:0] total_q;
  logic [COUNT_W-1:0] count_q;
  logic [TIME_W-1:0]  dt_q;
  logic               rev_done_q;
  logic [DIST_W-1:0]  dist_q;
  logic               fresh_q;

  // output register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  logic               in_fire;
  logic               out_take;
  logic [WHEEL_W-1:0] in_wheel;
  logic [TOTAL_W-1:0] total_new;
  logic [COUNT_W-1:0] count_new;
  logic [COUNT_W-1:0] target;
  logic               rev_done_new;
  logic [TIME_W-1:0]  dt_new;
  logic               need_speed;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  div_ctl_t           div_ctl;
  logic [NUM_W-1:0]   div_q;
  logic [SPEED_W-1:0] speed_sat;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_wheel      = s_axis_tuser;

  // edge bookkeeping, all taken from state at the accepted transaction
  assign total_new    = notch_total_q[in_wheel] + TOTAL_W'(1);
  assign count_new    = {1'b0, rev_notches_q[in_wheel]} + COUNT_W'(1);
  assign target       = (npr_q == '0) ? FULL_REV : {1'b0, npr_q};
  assign rev_done_new = (count_new >= target);
  assign dt_new       = s_axis_tdata - last_rev_time_q[in_wheel];

  assign need_speed   = rev_done_q && (dt_q != '0);

  // result leaves S_DONE once the output register can take it
  assign out_take     = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  // saturate the 45-bit quotient to 32 bits
  assign speed_sat = (div_q[NUM_W-1:SPEED_W] != '0) ? '1 : div_q[SPEED_W-1:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_DIST: begin
        mul_a = total_q;
        mul_b = MUL_B_W'(cm_q);
      end
      S_SPD1: begin
        mul_a = MUL_A_W'(count_q);
        mul_b = MUL_B_W'(cm_q);
      end
      S_SPD2: begin
        mul_a = MUL_A_W'(mul_p[CNT_CM_W-1:0]);
        mul_b = US_PER_SECOND;
      end
      S_IDLE, S_DIVST, S_DIV, S_DONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_ctl.start = (state_q == S_DIVST);

  // the distance product is caught in S_SPD1; waiting on a
  // full output register happens only in S_DONE
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_DIST;
      S_DIST:  state_d = S_SPD1;
      S_SPD1:  state_d = need_speed ? S_SPD2 : S_DONE;
      S_SPD2:  state_d = S_DIVST;
      S_DIVST: state_d = S_DIV;
      S_DIV:   if (div_ctl.done) state_d = S_DONE;
      S_DONE:  if (out_take) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cm_q  <= CM_RESET;
      npr_q <= NPR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NOTCH_PITCH:     cm_q  <= cfg_data_i[CM_W-1:0];
        CFG_NOTCHES_PER_REV: npr_q <= cfg_data_i[REV_W-1:0];
        default: ;
      endcase
    end
  end

  // per-wheel state; speed written when the divide completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WHEEL_COUNT; k++) begin
        notch_total_q[k]   <= '0;
        rev_notches_q[k]   <= '0;
        last_rev_time_q[k] <= '0;
        wheel_speed_q[k]   <= '0;
      end
    end else begin
      if (in_fire) begin
        notch_total_q[in_wheel] <= total_new;
        if (rev_done_new) begin
          rev_notches_q[in_wheel]   <= '0;
          last_rev_time_q[in_wheel] <= s_axis_tdata;
        end else begin
          rev_notches_q[in_wheel] <= count_new[REV_W-1:0];
        end
      end
      if ((state_q == S_DIV) && div_ctl.done) begin
        wheel_speed_q[wheel_q] <= speed_sat;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      wheel_q    <= in_wheel;
      total_q    <= total_new;
      count_q    <= count_new;
      dt_q       <= dt_new;
      rev_done_q <= rev_done_new;
    end
    if (state_q == S_SPD1) begin
      dist_q <= mul_p[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b0;
    end else if (in_fire) begin
      fresh_q <= 1'b0;
    end else if ((state_q == S_DIV) && div_ctl.done) begin
      fresh_q <= 1'b1;
    end
  end

  // output register; the wheel's stored speed is already current in S_DONE
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_data_q <= {wheel_speed_q[wheel_q], dist_q, total_q};
      out_user_q <= {fresh_q, wheel_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  wenc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  wenc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_ctl.start),
    .dividend_i (mul_p[NUM_W-1:0]),
    .divisor_i  (dt_q),
    .done_o     (div_ctl.done),
    .quotient_o (div_q)
  );

  // divider reports completion only while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.done |-> (state_q == S_DIV))
    else $error("divider done outside divide wait");

  // a divide is never launched on a zero interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVST) |-> (dt_q != '0))
    else $error("divide started with zero interval");

  // every accepted edge leads to the distance step next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_DIST))
    else $error("accepted edge did not start work");

  // a fresh speed only follows a finished revolution with a nonzero interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && fresh_q) |-> need_speed)
    else $error("fresh speed without divide");

  // a stalled result holds steady
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

endmodule : wheel_encoder_odometry_unit
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import wenc_pkg::*;

  localparam int unsigned HALF_PERIOD     = 5;
  localparam int unsigned RESET_CYCLES    = 8;
  // slowest edge is a speed refresh; the settle window covers it
  localparam int unsigned SETTLE_CYCLES   = 64;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned EDGES_PER_PHASE = 205;

  // one result transaction, unpacked from m_axis
  typedef struct packed {
    logic               which;
    logic [TOTAL_W-1:0] total;
    logic [DIST_W-1:0]  distance;
    logic [SPEED_W-1:0] speed;
    logic               fresh;
  } odo_result_t;

  typedef enum logic {
    ROW_EDGE,
    ROW_CFG
  } row_kind_e;

  // directed stimulus row: an edge (sel = wheel, val = timestamp) or a
  // register write (sel = register index, val = write data)
  typedef struct packed {
    row_kind_e         kind;
    logic              sel;
    logic [TIME_W-1:0] val;
    logic              typed;  // want holds a hand-computed result
    odo_result_t       want;
  } stim_row_t;

  // ---------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TIME_W-1:0]     s_axis_tdata  = '0;   // [63:0] now_us
  logic [WHEEL_W-1:0]    s_axis_tuser  = '0;   // [0] wheel
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // [31:0] total, [79:32] distance, [111:80] speed
  logic [OUT_USER_W-1:0] m_axis_tuser;         // [0] which_wheel, [1] speed_new

  wheel_encoder_odometry_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // run limit, far above the slowest legal run of about 1700 notch events
  initial begin
    #(10_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Odometry predictor: own copy of registers and per-wheel state
  // ---------------------------------------------------------------------
  logic [CM_W-1:0]    cm_q12;
  logic [REV_W-1:0]   rev_target;
  logic [TOTAL_W-1:0] notch_cnt  [WHEEL_COUNT];
  logic [REV_W-1:0]   rev_cnt    [WHEEL_COUNT];
  logic [TIME_W-1:0]  rev_stamp  [WHEEL_COUNT];
  logic [SPEED_W-1:0] wheel_rate [WHEEL_COUNT];

  odo_result_t pending_results [$];
  int unsigned mismatches = 0;

  // idle/stall knobs, percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // bumped by stimulus to request one long receiver hold-off
  int unsigned hold_reqs = 0;

  function automatic odo_result_t predict_edge(logic w, logic [TIME_W-1:0] now);
    logic [COUNT_W-1:0] cnt;
    logic [COUNT_W-1:0] goal;
    logic [TIME_W-1:0]  dt;
    logic [TIME_W-1:0]  dividend;
    logic [TIME_W-1:0]  quot;
    odo_result_t        r;
    notch_cnt[w] = notch_cnt[w] + 1'b1;
    cnt  = COUNT_W'(rev_cnt[w]) + 1'b1;
    // a zero register means a full 256-notch revolution
    goal = (rev_target == '0) ? FULL_REV : COUNT_W'(rev_target);
    r.fresh = 1'b0;
    // >= so that lowering the register mid-revolution completes at once
    if (cnt >= goal) begin
      dt = now - rev_stamp[w];   // wraps if time went backwards
      if (dt != '0) begin
        dividend = TIME_W'(cnt) * TIME_W'(cm_q12) * TIME_W'(US_PER_SECOND);
        quot     = dividend / dt;
        wheel_rate[w] = (quot > 64'h0000_0000_FFFF_FFFF) ? '1 : quot[SPEED_W-1:0];
        r.fresh  = 1'b1;
      end
      rev_stamp[w] = now;
      rev_cnt[w]   = '0;
    end else begin
      rev_cnt[w] = cnt[REV_W-1:0];
    end
    r.which    = w;
    r.total    = notch_cnt[w];
    r.distance = DIST_W'(TIME_W'(notch_cnt[w]) * TIME_W'(cm_q12));
    r.speed    = wheel_rate[w];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, field, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Sender side: drive at falling edge, accept at rising edge
  // ---------------------------------------------------------------------
  task automatic send_edge(logic w, logic [TIME_W-1:0] now, logic typed, odo_result_t want);
    odo_result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= now;
    s_axis_tuser  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // transaction accepted at this edge
    pred = predict_edge(w, now);
    pending_results.push_back(typed ? want : pred);
  endtask

  // stop offering, wait for every result, then let the block settle
  task automatic drain_results(int unsigned extra);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  // register writes only while the block is idle
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    drain_results(SETTLE_CYCLES);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == CFG_NOTCH_PITCH) cm_q12 = data[CM_W-1:0];
    else                        rev_target = data[REV_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: random stalls plus one-off long hold-offs
  // ---------------------------------------------------------------------
  initial begin : recv_ready
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result checker: compare each transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    odo_result_t got;
    odo_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.which    = m_axis_tuser[0];
      got.fresh    = m_axis_tuser[1];
      got.total    = m_axis_tdata[31:0];
      got.distance = m_axis_tdata[79:32];
      got.speed    = m_axis_tdata[111:80];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result (total)", 64'(got.total), 64'h0);
      end else begin
        want = pending_results.pop_front();
        if (got.which !== want.which)
          report_mismatch("which_wheel", 64'(got.which), 64'(want.which));
        if (got.total !== want.total)
          report_mismatch("total_notches", 64'(got.total), 64'(want.total));
        if (got.distance !== want.distance)
          report_mismatch("distance_q12", 64'(got.distance), 64'(want.distance));
        if (got.speed !== want.speed)
          report_mismatch("speed_q12", 64'(got.speed), 64'(want.speed));
        if (got.fresh !== want.fresh)
          report_mismatch("speed_new", 64'(got.fresh), 64'(want.fresh));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t         dir_rows [$];
    stim_row_t         row;
    logic [TIME_W-1:0] wheel_clock [WHEEL_COUNT];
    logic              w;
    int unsigned       pick;

    // predictor starts from the reset values
    cm_q12     = CM_RESET;
    rev_target = NPR_RESET;
    for (int k = 0; k < WHEEL_COUNT; k++) begin
      notch_cnt[k]   = '0;
      rev_cnt[k]     = '0;
      rev_stamp[k]   = '0;
      wheel_rate[k]  = '0;
      wheel_clock[k] = '0;
    end

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table; hand results only where obvious, the rest predicted
    // first edge of each wheel after reset: no revolution yet
    dir_rows.push_back('{ROW_EDGE, 1'b0, 64'd100, 1'b1,
                         '{1'b0, 32'd1, 48'd4096, 32'd0, 1'b0}});
    dir_rows.push_back('{ROW_EDGE, 1'b1, 64'd0, 1'b1,
                         '{1'b1, 32'd1, 48'd4096, 32'd0, 1'b0}});
    // one notch per revolution; count already at the new target
    dir_rows.push_back('{ROW_CFG, CFG_NOTCHES_PER_REV, 64'h0000_0000_0000_0001, 1'b0, '0});
    dir_rows.push_back('{ROW_EDGE, 1'b0, 64'd1000, 1'b0, '0});
    // same timestamp: zero interval keeps the speed
    dir_rows.push_back('{ROW_EDGE, 1'b0, 64'd1000, 1'b0, '0});
    // time going backwards: huge wrapped interval
    dir_rows.push_back('{ROW_EDGE, 1'b0, 64'd1, 1'b0, '0});
    // first interval of wheel 1 from time zero, and zero interval
    dir_rows.push_back('{ROW_EDGE, 1'b1, 64'd0, 1'b0, '0});
    dir_rows.push_back('{ROW_EDGE, 1'b1, 64'd1, 1'b0, '0});
    // max distance per notch over 1 us: speed saturates
    dir_rows.push_back('{ROW_CFG, CFG_NOTCH_PITCH, 64'h0000_0000_0000_FFFF, 1'b0, '0});
    dir_rows.push_back('{ROW_EDGE, 1'b1, 64'd2, 1'b1,
                         '{1'b1, 32'd4, 48'd262140, 32'hFFFF_FFFF, 1'b1}});
    dir_rows.push_back('{ROW_EDGE, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0});
    // zero distance per notch: distance and new speed both zero
    dir_rows.push_back('{ROW_CFG, CFG_NOTCH_PITCH, 64'h0, 1'b0, '0});
    dir_rows.push_back('{ROW_EDGE, 1'b0, 64'd5, 1'b1,
                         '{1'b0, 32'd6, 48'd0, 32'd0, 1'b1}});
    // zero target means 256 notches; upper data bits are don't-care
    dir_rows.push_back('{ROW_CFG, CFG_NOTCH_PITCH, 64'h0000_0000_0000_1000, 1'b0, '0});
    dir_rows.push_back('{ROW_CFG, CFG_NOTCHES_PER_REV, 64'h0000_0000_0000_A500, 1'b0, '0});
    dir_rows.push_back('{ROW_EDGE, 1'b1, 64'd10, 1'b0, '0});
    dir_rows.push_back('{ROW_CFG, CFG_NOTCHES_PER_REV, 64'h0000_0000_0000_5AFF, 1'b0, '0});
    dir_rows.push_back('{ROW_EDGE, 1'b1, 64'd20, 1'b0, '0});
    dir_rows.push_back('{ROW_EDGE, 1'b1, 64'd30, 1'b0, '0});
    dir_rows.push_back('{ROW_EDGE, 1'b0, 64'h8000_0000_0000_0000, 1'b0, '0});
    // target lowered below the count reached: completes on next edge
    dir_rows.push_back('{ROW_CFG, CFG_NOTCHES_PER_REV, 64'h0000_0000_0000_0002, 1'b0, '0});
    dir_rows.push_back('{ROW_EDGE, 1'b1, 64'd40, 1'b0, '0});
    dir_rows.push_back('{ROW_EDGE, 1'b0, 64'h8000_0000_0000_0003, 1'b0, '0});

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) write_reg(cfg_idx_e'(row.sel), row.val[CFG_DATA_W-1:0]);
      else                     send_edge(row.sel, row.val, row.typed, row.want);
    end
    for (int k = 0; k < WHEEL_COUNT; k++) wheel_clock[k] = 64'h8000_0000_0000_0003;

    // random phases: each cycles through an idle mode and a new setting
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      write_reg(CFG_NOTCH_PITCH,
                (p == 1) ? 16'hFFFF : (p == 6) ? 16'h0000 : 16'($urandom_range(65535)));
      // mostly short revolutions so speed refreshes often; 255 then a
      // small value exercises lowering the target mid-revolution
      write_reg(CFG_NOTCHES_PER_REV,
                {8'($urandom), (p == 3) ? 8'd255 : (p == 5) ? 8'd0 : 8'($urandom_range(6, 1))});

      for (int n = 0; n < EDGES_PER_PHASE; n++) begin
        // long receiver hold-off while edges keep coming: block backs up
        if (n == 60) hold_reqs++;
        // sender pause until every result is back
        if (n == 130) drain_results(0);
        w    = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 70)      wheel_clock[w] = wheel_clock[w] + 64'($urandom_range(4000, 1));
        else if (pick < 80) wheel_clock[w] = wheel_clock[w];      // zero interval
        else if (pick < 87) wheel_clock[w] = wheel_clock[w] - 64'($urandom_range(1000, 1));
        else if (pick < 93) wheel_clock[w] = wheel_clock[w] + {32'h0, $urandom};
        else                wheel_clock[w] = {$urandom, $urandom};
        send_edge(w, wheel_clock[w], 1'b0, '0);
      end
    end

    // all edges in; wait for the last results and a settle window
    drain_results(SETTLE_CYCLES);
    if (pending_results.size() != 0)
      report_mismatch("results outstanding", 64'(pending_results.size()), 64'h0);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* wheel_encoder_odometry_unit.f */
rtl/wenc_pkg.sv
rtl/wenc_mul.sv
rtl/wenc_div.sv
rtl/wheel_encoder_odometry_unit.sv
dv/tb.sv
